/* src/edsm_pkg.sv */
// ----------------------------------------------------------------------------
// edsm_pkg
// Types and constants shared by the encoder delta speed meter and its divider.
// ----------------------------------------------------------------------------
package edsm_pkg;

  localparam int unsigned QUOT_W    = 32;
  localparam int unsigned NUM_W     = 41;
  localparam int unsigned DEN_W     = 48;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [9:0] SPEED_SCALE = 10'd1000;

  localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_COUNTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_REV   = 2'd2;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

endpackage

/* src/edsm_div.sv */
// ----------------------------------------------------------------------------
// edsm_div
// Restoring divider, one quotient bit per cycle: (num << FRAC) / den, with an
// overflow flag when the quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
module edsm_div
  import edsm_pkg::*;
#(
  parameter int unsigned SPEED_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic              ovf_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned NW    = NUM_W + SPEED_FRAC_BITS;
  localparam int unsigned HW    = NW - QUOT_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic [NW-1:0]     n_full;
  logic [HW-1:0]     n_hi;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W-1:0]  rem_d, rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [QUOT_W-1:0] low_d, low_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              ovf_q;

  assign n_full = {num_i, {SPEED_FRAC_BITS{1'b0}}};
  assign n_hi   = n_full[NW-1:QUOT_W];

  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  always_comb begin
    rem_d = trial[DEN_W-1:0];
    if (ge) begin
      rem_d = DEN_W'(trial - {1'b0, den_q});
    end
    low_d = {low_q[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(n_hi);
      low_q <= n_full[QUOT_W-1:0];
      den_q <= den_i;
      ovf_q <= DEN_W'(n_hi) >= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = low_q;

endmodule

/* src/encoder_delta_speed_meter.sv */
// ----------------------------------------------------------------------------
// encoder_delta_speed_meter
// Speed from successive encoder counter samples, signed fixed point rev/s.
// ----------------------------------------------------------------------------
// Input beats (valid/ready) carry an opcode, a counter sample and a tick.
// With nonzero counts per revolution, a measure beat forms the wrap-aware
// count delta, updates the running total and, with nonzero elapsed ticks,
// divides delta*1000 by ticks times counts per revolution.
// A restart beat latches the sample and clears speed, delta and total.
// Each input beat yields exactly one output beat (valid/ready).
// With a division, a beat passes through prepare, multiply, divider start
// and the bit-serial divide, then the quotient is taken and the output
// register loaded; otherwise prepare leads straight to the output register.
// One item at a time; ready rises with the edge that loads the output register.
// A stalled receiver holds the result in the output register and the next
// item waits in the final state until the register frees.
// Reset clears configuration, measurement state and both handshakes.
// Configuration is a plain write port (enable, index, data), to be written
// idle by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module encoder_delta_speed_meter
  import edsm_pkg::*;
#(
  parameter int unsigned SPEED_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [31:0]          counter_value_i,
  input  logic [31:0]          tick_now_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   speed_q16_o,
  output logic                 speed_saturated_o,
  output logic signed [31:0]   delta_out_o,
  output logic signed [31:0]   total_out_o
);

  state_e state_q, state_d;

  logic             wide_q, rev_q;
  logic [CFG_W-1:0] ppr_q;

  logic [31:0] prev_count_q, prev_tick_q, held_speed_q, held_delta_q, total_q;
  logic        op_q;
  logic [31:0] count_q, tick_q;

  logic              neg_q;
  logic [31:0]       mag_q, dt_q;
  logic [NUM_W-1:0]  num_d, num_q;
  logic [DEN_W-1:0]  den_d, den_q;
  logic [31:0]       res_speed_q;
  logic              res_sat_q;

  logic        out_valid_q;
  logic [31:0] speed_o_q, delta_o_q, total_o_q;
  logic        sat_o_q;

  logic [31:0] diff_w, delta_raw, delta_c, dt_c;
  logic [15:0] diff_n;

  logic              div_start, div_done, div_ovf;
  logic [QUOT_W-1:0] div_quot;
  logic [31:0]       fin_speed;
  logic              fin_sat;
  logic              out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_start  = (state_q == S_START);

  assign diff_w    = count_q - prev_count_q;
  assign diff_n    = diff_w[15:0];
  assign delta_raw = wide_q ? diff_w : {{16{diff_n[15]}}, diff_n};
  assign delta_c   = rev_q ? (32'd0 - delta_raw) : delta_raw;
  assign dt_c      = tick_q - prev_tick_q;

  assign num_d = NUM_W'(mag_q) * NUM_W'(SPEED_SCALE);
  assign den_d = DEN_W'(dt_q) * DEN_W'(ppr_q);

  edsm_div #(
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .ovf_o  (div_ovf),
    .quot_o (div_quot)
  );

  always_comb begin
    fin_sat   = 1'b0;
    fin_speed = div_quot;
    if (div_ovf) begin
      fin_sat   = 1'b1;
      fin_speed = neg_q ? SPEED_MIN : SPEED_MAX;
    end else if (neg_q) begin
      if (div_quot > SPEED_MIN) begin
        fin_sat   = 1'b1;
        fin_speed = SPEED_MIN;
      end else begin
        fin_speed = 32'd0 - div_quot;
      end
    end else if (div_quot[31]) begin
      fin_sat   = 1'b1;
      fin_speed = SPEED_MAX;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (op_q == OP_MEASURE && ppr_q != '0 && dt_c != '0) begin
          state_d = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wide_q       <= 1'b0;
      rev_q        <= 1'b0;
      ppr_q        <= '0;
      prev_count_q <= '0;
      prev_tick_q  <= '0;
      held_speed_q <= '0;
      held_delta_q <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDE_COUNTER: wide_q <= cfg_wdata_i[0];
          CFG_REVERSE_DIR:  rev_q  <= cfg_wdata_i[0];
          CFG_PULSES_REV:   ppr_q  <= cfg_wdata_i;
          default:          ;
        endcase
      end
      if (state_q == S_PREP) begin
        if (op_q == OP_RESTART) begin
          prev_count_q <= count_q;
          prev_tick_q  <= tick_q;
          held_speed_q <= '0;
          held_delta_q <= '0;
          total_q      <= '0;
        end else if (ppr_q != '0) begin
          prev_count_q <= count_q;
          prev_tick_q  <= tick_q;
          held_delta_q <= delta_c;
          total_q      <= total_q + delta_c;
        end
      end
      if (state_q == S_DIV && div_done) begin
        held_speed_q <= fin_speed;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q    <= opcode_i;
      count_q <= counter_value_i;
      tick_q  <= tick_now_i;
    end
    if (state_q == S_PREP) begin
      neg_q     <= delta_c[31];
      mag_q     <= delta_c[31] ? (32'd0 - delta_c) : delta_c;
      dt_q      <= dt_c;
      res_sat_q <= 1'b0;
      if (op_q == OP_RESTART || ppr_q == '0) begin
        res_speed_q <= '0;
      end else begin
        res_speed_q <= held_speed_q;
      end
    end
    if (state_q == S_MUL) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (state_q == S_DIV && div_done) begin
      res_speed_q <= fin_speed;
      res_sat_q   <= fin_sat;
    end
    if (state_q == S_OUT && out_free) begin
      speed_o_q <= res_speed_q;
      sat_o_q   <= res_sat_q;
      delta_o_q <= held_delta_q;
      total_o_q <= total_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign speed_q16_o       = signed'(speed_o_q);
  assign speed_saturated_o = sat_o_q;
  assign delta_out_o       = signed'(delta_o_q);
  assign total_out_o       = signed'(total_o_q);

endmodule
